// ----- hdl/tzc_pkg.sv -----
// Shared types, constants and DST tables for the timezone/DST epoch converter.
// No dependencies; every other file imports this package.
`default_nettype none

package tzc_pkg;

   localparam longint unsigned EPOCH_2000 = 64'd946684800;
   localparam longint unsigned EPOCH_LAST = 64'd4102444799;
   localparam int unsigned     SECS_DAY   = 86400;
   localparam int unsigned     NUM_YEARS  = 100;

   localparam logic [31:0] EPOCH_LO = 32'd946684800;
   localparam logic [31:0] EPOCH_HI = 32'd4102444799;

   // register indexes and DST mode codes
   localparam logic       CSR_ZONE = 1'b0;
   localparam logic       CSR_DST  = 1'b1;
   localparam logic [1:0] DST_OFF  = 2'd0;
   localparam logic [1:0] DST_ON   = 2'd1;
   localparam logic [1:0] DST_AUTO = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [31:0] epoch_in;
   } tzc_req_type;

   typedef struct packed {
      logic [31:0] epoch_out;
      logic        dst_active;
   } tzc_rsp_type;

   // carried alongside a judge pass
   typedef struct packed {
      logic               mode;
      logic signed [34:0] base;
      logic               act;
   } tzc_side_type;

   typedef struct packed {
      logic               valid;
      logic signed [34:0] utc;
      tzc_side_type       side;
   } tzc_jin_type;

   typedef struct packed {
      logic         valid;
      logic         eu;
      tzc_side_type side;
   } tzc_jout_type;

   typedef logic [31:0] tzc_tab_type [NUM_YEARS];

   // Epoch second of (last Sunday of a 31-day month) + hour offset, per year.
   // Evaluated at elaboration only.
   function automatic tzc_tab_type tzc_build(input longint unsigned last_day,
                                             input longint unsigned hour_sec);
      tzc_tab_type    tab;
      longint unsigned d;
      longint unsigned wd;
      longint unsigned leap;
      for (int n = 0; n < NUM_YEARS; n++) begin
         leap   = ((n % 4) == 0) ? 64'd1 : 64'd0;
         d      = 365 * longint'(n) + (longint'(n) + 3) / 4 + last_day + leap;
         wd     = (d + 6) % 7;
         tab[n] = 32'(EPOCH_2000 + (d - wd) * SECS_DAY + hour_sec);
      end
      return tab;
   endfunction

   localparam tzc_tab_type MAR_TAB = tzc_build(64'd89, 64'd7200);
   localparam tzc_tab_type OCT_TAB = tzc_build(64'd303, 64'd10800);

   function automatic logic dst_on(input logic [1:0] dm, input logic eu,
                                   input logic shift_nz);
      return shift_nz && ((dm == DST_ON) || ((dm == DST_AUTO) && eu));
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tzc_judge.sv -----
// Five-stage EU rule judge: clamp, day count, 4-year cycle, year, table compare.
// Depends on tzc_pkg (tables, bundle types).
`default_nettype none

module tzc_judge #(
   parameter int unsigned DST_SHIFT_MINUTES = 60
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      en,
   input  wire logic signed [34:0]  zone_sec,
   input  wire tzc_pkg::tzc_jin_type  jin,
   output tzc_pkg::tzc_jout_type      jout
);
   import tzc_pkg::*;

   localparam logic signed [34:0] END_ADJ = 35'(DST_SHIFT_MINUTES * 60);
   localparam logic [25:0] DAY_MUL = 26'd50903317;  // 2^35/675, rounded up
   localparam logic [17:0] CYC_MUL = 18'd183735;    // 2^28/1461, rounded up
   localparam logic signed [34:0] LO_S = 35'(EPOCH_2000);
   localparam logic signed [34:0] HI_S = 35'(EPOCH_LAST);

   logic [4:0]          v_ff, v_in;
   tzc_side_type        s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic signed [34:0]  loc1_ff, loc2_ff, loc3_ff, loc4_ff;
   logic [31:0]         off1_ff, off1_in;
   logic [15:0]         days2_ff, days3_ff, days2_in;
   logic [4:0]          cyc3_ff, cyc3_in;
   logic [6:0]          yr4_ff, yr4_in;
   logic                eu5_ff, eu5_in;
   logic [50:0]         prod_day;
   logic [33:0]         prod_cyc;
   logic [15:0]         rem;
   logic [1:0]          yoff;

   assign v_in = {v_ff[3:0], jin.valid};

   always_comb begin
      if (jin.utc < LO_S) begin
         off1_in = '0;
      end else if (jin.utc > HI_S) begin
         off1_in = 32'(EPOCH_LAST - EPOCH_2000);
      end else begin
         off1_in = 32'(jin.utc - LO_S);
      end
   end

   // seconds / 86400 == (seconds >> 7) / 675
   assign prod_day = 51'(off1_ff[31:7]) * 51'(DAY_MUL);
   assign days2_in = prod_day[50:35];

   assign prod_cyc = 34'(days2_ff) * 34'(CYC_MUL);
   assign cyc3_in  = prod_cyc[32:28];

   always_comb begin
      rem = days3_ff - (16'(cyc3_ff) * 16'd1461);
      priority if (rem < 16'd366) begin
         yoff = 2'd0;
      end else if (rem < 16'd731) begin
         yoff = 2'd1;
      end else if (rem < 16'd1096) begin
         yoff = 2'd2;
      end else begin
         yoff = 2'd3;
      end
      yr4_in = {cyc3_ff, yoff};
   end

   // end instant is in summer time, so the shift moves to the local side
   assign eu5_in = (loc4_ff >= $signed({3'b000, MAR_TAB[yr4_ff]}))
                && ((loc4_ff + END_ADJ) < $signed({3'b000, OCT_TAB[yr4_ff]}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff    <= jin.side;
         s2_ff    <= s1_ff;
         s3_ff    <= s2_ff;
         s4_ff    <= s3_ff;
         s5_ff    <= s4_ff;
         loc1_ff  <= jin.utc + zone_sec;
         loc2_ff  <= loc1_ff;
         loc3_ff  <= loc2_ff;
         loc4_ff  <= loc3_ff;
         off1_ff  <= off1_in;
         days2_ff <= days2_in;
         days3_ff <= days2_ff;
         cyc3_ff  <= cyc3_in;
         yr4_ff   <= yr4_in;
         eu5_ff   <= eu5_in;
      end
   end

   assign jout.valid = v_ff[4];
   assign jout.eu    = eu5_ff;
   assign jout.side  = s5_ff;

endmodule

`default_nettype wire

// ----- hdl/timezone_dst_epoch_converter_core.sv -----
// Top level of the UTC/local epoch converter with EU daylight saving rule.
// Depends on tzc_pkg and tzc_judge.
//
//   channel | dir | handshake          | beat
//   req     | in  | req_valid/req_stall | tzc_req_type
//   rsp     | out | rsp_valid/rsp_stall | tzc_rsp_type
//   csr     | in  | csr_we              | csr_index, csr_wdata
//
// One beat per cycle sustained unless rsp stalls; stages are an entry stage,
// two 5-stage judge passes, a mid stage and an output register. The two
// judges run in series because direction 1 judges again on its own result.
// Reset clears valids and config registers (zone 0, DST off). A stall at rsp
// with rsp_valid high freezes the pipeline and stalls req in the same cycle.
`default_nettype none

module timezone_dst_epoch_converter_core #(
   parameter int unsigned DST_SHIFT_MINUTES = 60
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire tzc_pkg::tzc_req_type req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output tzc_pkg::tzc_rsp_type      rsp_data,
   input  wire                       csr_we,
   input  wire                       csr_index,
   input  wire [10:0]                csr_wdata
);
   import tzc_pkg::*;

   localparam logic signed [34:0] DST_SEC  = 35'(DST_SHIFT_MINUTES * 60);
   localparam logic               SHIFT_NZ = (DST_SHIFT_MINUTES != 0);
   localparam logic signed [34:0] LO_S = 35'(EPOCH_2000);
   localparam logic signed [34:0] HI_S = 35'(EPOCH_LAST);

   logic signed [10:0] zone_ff;
   logic [1:0]         dstm_ff;
   logic signed [34:0] zone_sec;
   logic               en;

   tzc_jin_type  j1_in_ff, j1_in_in, j2_in_ff, j2_in_in;
   tzc_jout_type j1_out, j2_out;
   logic         on1, on2;
   logic signed [34:0] t_in, adj1, res_c;
   logic         rsp_valid_ff;
   tzc_rsp_type  rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= '0;
         dstm_ff <= DST_OFF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ZONE: zone_ff <= csr_wdata;
            CSR_DST:  dstm_ff <= csr_wdata[1:0];
            default:  zone_ff <= zone_ff;
         endcase
      end
   end

   assign zone_sec  = 35'(zone_ff) * 35'sd60;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // entry: direction 1 removes the zone first and judges that
   always_comb begin
      t_in              = $signed({3'b000, req_data.epoch_in});
      j1_in_in.valid     = req_valid;
      j1_in_in.side.mode = req_data.mode;
      j1_in_in.side.act  = 1'b0;
      if (req_data.mode) begin
         j1_in_in.utc       = t_in - zone_sec;
         j1_in_in.side.base = t_in - zone_sec;
      end else begin
         j1_in_in.utc       = t_in;
         j1_in_in.side.base = t_in + zone_sec;
      end
   end

   tzc_judge #(.DST_SHIFT_MINUTES(DST_SHIFT_MINUTES)) u_judge1 (
      .clock(clock), .reset(reset), .en(en), .zone_sec(zone_sec),
      .jin(j1_in_ff), .jout(j1_out)
   );

   always_comb begin
      on1  = dst_on(dstm_ff, j1_out.eu, SHIFT_NZ);
      adj1 = on1 ? DST_SEC : '0;
      res_c = j1_out.side.mode ? (j1_out.side.base - adj1)
                               : (j1_out.side.base + adj1);
      j2_in_in.valid     = j1_out.valid;
      j2_in_in.utc       = res_c;
      j2_in_in.side.mode = j1_out.side.mode;
      j2_in_in.side.base = res_c;
      j2_in_in.side.act  = on1;
   end

   tzc_judge #(.DST_SHIFT_MINUTES(DST_SHIFT_MINUTES)) u_judge2 (
      .clock(clock), .reset(reset), .en(en), .zone_sec(zone_sec),
      .jin(j2_in_ff), .jout(j2_out)
   );

   always_comb begin
      on2 = dst_on(dstm_ff, j2_out.eu, SHIFT_NZ);
      rsp_in.dst_active = j2_out.side.mode ? on2 : j2_out.side.act;
      if (j2_out.side.base < LO_S) begin
         rsp_in.epoch_out = EPOCH_LO;
      end else if (j2_out.side.base > HI_S) begin
         rsp_in.epoch_out = EPOCH_HI;
      end else begin
         rsp_in.epoch_out = j2_out.side.base[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j1_in_ff.valid <= 1'b0;
         j2_in_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (en) begin
         j1_in_ff       <= j1_in_in;
         j2_in_ff       <= j2_in_in;
         rsp_valid_ff   <= j2_out.valid;
         rsp_ff         <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- hdl/tzc_checker.sv -----
// Port-level checks for the converter top level, attached by bind.
// Depends on tzc_pkg.
`default_nettype none

module tzc_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       rsp_valid,
   input wire                       rsp_stall,
   input wire                       req_stall,
   input wire tzc_pkg::tzc_rsp_type rsp_data
);
   import tzc_pkg::*;

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.epoch_out >= EPOCH_LO) && (rsp_data.epoch_out <= EPOCH_HI))
      else $error("epoch_out outside supported years");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled beat changed");

   a_back: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind timezone_dst_epoch_converter_core tzc_checker u_tzc_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .req_stall(req_stall), .rsp_data(rsp_data)
);

`default_nettype wire

// ----- tb/timezone_dst_epoch_converter_core_tb.sv -----
// Self-checking testbench for the UTC/local epoch converter with EU DST rule.
// Depends on tzc_pkg and timezone_dst_epoch_converter_core; directed table + random beats.
`timescale 1ns / 1ps

module timezone_dst_epoch_converter_core_tb;
   import tzc_pkg::*;

   localparam longint     SHIFT_MIN   = 60;
   localparam logic [1:0] DST_SPARE   = 2'd3;
   localparam logic       DIR_TO_LOC  = 1'b0;
   localparam logic       DIR_TO_UTC  = 1'b1;
   localparam int         PIPE_CYCLES = 20;
   localparam int         RAND_PHASES = 12;
   localparam int         PHASE_BEATS = 145;

   typedef struct packed {
      logic signed [10:0] zone;
      logic [1:0]         dmode;
      logic               dir;
      logic [31:0]        epoch;
      logic               typed;
      logic [31:0]        x_epoch;
      logic               x_act;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tzc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tzc_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_ZONE;
   logic [10:0] csr_wdata = '0;

   logic signed [10:0] cfg_zone = '0;
   logic [1:0]         cfg_dst = DST_OFF;
   tzc_rsp_type        expected_q[$];
   int                 n_errors = 0;
   int                 n_sent = 0;
   int                 n_checked = 0;
   int                 n_summer = 0;
   int                 n_configs = 0;

   timezone_dst_epoch_converter_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------- conversion predictor ----------------
   function automatic longint days_to_year(longint y);
      longint n;
      n = y - 2000;
      return 365 * n + (n + 3) / 4;
   endfunction

   function automatic longint clamp_span(longint t);
      if (t < longint'(EPOCH_2000)) return longint'(EPOCH_2000);
      if (t > longint'(EPOCH_LAST)) return longint'(EPOCH_LAST);
      return t;
   endfunction

   // 00:00 of the last Sunday of a 31-day month (day 0 = Sat 2000-01-01)
   function automatic longint last_sunday(longint y, longint last_day);
      longint d;
      d = days_to_year(y) + last_day;
      return longint'(EPOCH_2000) + (d - (d + 6) % 7) * 86400;
   endfunction

   function automatic bit eu_summer(longint utc);
      longint days, y, leap, zs, t_on, t_off;
      zs   = longint'(cfg_zone);
      days = (clamp_span(utc) - longint'(EPOCH_2000)) / 86400;
      y    = 2000 + days / 366;
      while (y < 2099 && days_to_year(y + 1) <= days) y++;
      leap  = (y % 4 == 0) ? 1 : 0;
      t_on  = last_sunday(y, 89 + leap) + 7200 - zs * 60;
      t_off = last_sunday(y, 303 + leap) + 10800 - (zs + SHIFT_MIN) * 60;
      return (utc >= t_on) && (utc < t_off);
   endfunction

   function automatic longint dst_shift(longint utc);
      if (cfg_dst == DST_ON) return SHIFT_MIN;
      if (cfg_dst == DST_AUTO && eu_summer(utc)) return SHIFT_MIN;
      return 0;
   endfunction

   function automatic tzc_rsp_type convert_epoch(tzc_req_type r);
      tzc_rsp_type o;
      longint t, t1, res, dm;
      t = longint'({32'd0, r.epoch_in});
      if (r.mode == DIR_TO_LOC) begin
         dm  = dst_shift(t);
         res = t + longint'(cfg_zone) * 60 + dm * 60;
         o.dst_active = dm > 0;
      end else begin
         t1  = t - longint'(cfg_zone) * 60;
         dm  = dst_shift(t1);
         res = t1 - dm * 60;
         o.dst_active = dst_shift(res) > 0;
      end
      o.epoch_out = 32'(clamp_span(res));
      return o;
   endfunction

   // ---------------- helpers ----------------
   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH beat %0d: %s got %0d expected %0d", n_checked, what, got, want);
      n_errors++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic drain();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (PIPE_CYCLES) @(negedge clock);
   endtask

   // leaves csr_we high; the caller drops it
   task automatic write_csr(logic idx, logic [10:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      if (idx == CSR_ZONE) cfg_zone = val;
      else cfg_dst = val[1:0];
   endtask

   task automatic set_config(logic signed [10:0] zone, logic [1:0] dm);
      drain();
      write_csr(CSR_ZONE, zone);
      write_csr(CSR_DST, {9'd0, dm});
      csr_we <= 1'b0;
      n_configs++;
   endtask

   // called at a falling edge; returns at a falling edge
   task automatic send_beat(tzc_req_type r, bit typed, tzc_rsp_type want, bit gaps);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(typed ? want : convert_epoch(r));
      n_sent++;
      @(negedge clock);
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] near_switch(logic signed [10:0] zone);
      longint y, leap, b;
      y    = $urandom_range(2000, 2099);
      leap = (y % 4 == 0) ? 1 : 0;
      b    = last_sunday(y, ($urandom_range(0, 1) ? 89 : 303) + leap)
             + $urandom_range(0, 4) * 3600 - longint'(zone) * 60;
      b    = b + longint'($urandom_range(0, 14400)) - 7200;
      return 32'(b);
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("MISMATCH: result beat with nothing outstanding");
            n_errors++;
         end else begin
            tzc_rsp_type w;
            w = expected_q.pop_front();
            if (rsp_data.epoch_out !== w.epoch_out)
               report_mismatch("epoch_out", rsp_data.epoch_out, w.epoch_out);
            if (rsp_data.dst_active !== w.dst_active)
               report_mismatch("dst_active", rsp_data.dst_active, w.dst_active);
            if (w.dst_active) n_summer++;
            n_checked++;
         end
      end
   end

   // ---------------- receiver stalls ----------------
   initial begin
      int n;
      bit held;
      held = 0;
      @(negedge clock);
      while (1) begin
         if (!held && n_sent > 400) begin
            // long hold-off so the pipeline backs up into req
            held = 1;
            rsp_stall <= 1'b1;
            repeat (80) @(negedge clock);
         end
         n = pick_gap();
         rsp_stall <= (n > 0);
         repeat (n > 0 ? n : $urandom_range(1, 12)) @(negedge clock);
         if (n > 0) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // ---------------- stimulus ----------------
   vector_type vectors[] = '{
      '{11'sd0, DST_OFF, DIR_TO_LOC, 32'd946684800, 1'b1, 32'd946684800, 1'b0},
      '{11'sd0, DST_OFF, DIR_TO_LOC, 32'd0, 1'b1, 32'd946684800, 1'b0},
      '{11'sd0, DST_OFF, DIR_TO_UTC, 32'hFFFFFFFF, 1'b1, 32'd4102444799, 1'b0},
      '{11'sd840, DST_ON, DIR_TO_LOC, 32'd4102444799, 1'b1, 32'd4102444799, 1'b1},
      '{-11'sd720, DST_ON, DIR_TO_UTC, 32'd946684800, 1'b1, 32'd946724400, 1'b1},
      '{-11'sd1024, DST_SPARE, DIR_TO_LOC, 32'd1000000000, 1'b1, 32'd999938560, 1'b0},
      '{11'sd1023, DST_SPARE, DIR_TO_UTC, 32'd2000000000, 1'b1, 32'd1999938620, 1'b0},
      '{11'sd60, DST_AUTO, DIR_TO_LOC, 32'd1616893199, 1'b0, 32'd0, 1'b0},
      '{11'sd60, DST_AUTO, DIR_TO_LOC, 32'd1616893200, 1'b0, 32'd0, 1'b0},
      '{11'sd60, DST_AUTO, DIR_TO_LOC, 32'd1635641999, 1'b0, 32'd0, 1'b0},
      '{11'sd60, DST_AUTO, DIR_TO_LOC, 32'd1635642000, 1'b0, 32'd0, 1'b0},
      '{11'sd60, DST_AUTO, DIR_TO_UTC, 32'd1616896799, 1'b0, 32'd0, 1'b0},
      '{11'sd60, DST_AUTO, DIR_TO_UTC, 32'd1616898600, 1'b0, 32'd0, 1'b0},
      '{11'sd60, DST_AUTO, DIR_TO_UTC, 32'd1635645599, 1'b0, 32'd0, 1'b0},
      '{11'sd60, DST_AUTO, DIR_TO_UTC, 32'd1635649200, 1'b0, 32'd0, 1'b0},
      '{11'sd0, DST_AUTO, DIR_TO_LOC, 32'd0, 1'b0, 32'd0, 1'b0},
      '{11'sd0, DST_AUTO, DIR_TO_UTC, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0},
      '{11'sd0, DST_AUTO, DIR_TO_UTC, 32'd946684800, 1'b0, 32'd0, 1'b0},
      '{11'sd840, DST_AUTO, DIR_TO_LOC, 32'd1616893200, 1'b0, 32'd0, 1'b0},
      '{-11'sd720, DST_AUTO, DIR_TO_UTC, 32'd1635642000, 1'b0, 32'd0, 1'b0}
   };

   initial begin
      tzc_req_type        r;
      tzc_rsp_type        w;
      logic signed [10:0] zone;
      logic [1:0]         dm;
      int                 sel;
      bit                 gaps;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table; reset config is zone 0, DST off
      foreach (vectors[i]) begin
         if (vectors[i].zone != cfg_zone || vectors[i].dmode != cfg_dst) begin
            req_valid <= 1'b0;
            set_config(vectors[i].zone, vectors[i].dmode);
         end
         r.mode        = vectors[i].dir;
         r.epoch_in    = vectors[i].epoch;
         w.epoch_out   = vectors[i].x_epoch;
         w.dst_active  = vectors[i].x_act;
         send_beat(r, vectors[i].typed, w, 1'b1);
      end

      // random phases, mostly auto mode near the March/October switch instants
      for (int p = 0; p < RAND_PHASES; p++) begin
         req_valid <= 1'b0;
         sel = $urandom_range(0, 9);
         if (p == 0) zone = 11'sd840;
         else if (p == 1) zone = -11'sd720;
         else if (sel < 2) zone = 11'($urandom);
         else zone = 11'($signed($urandom_range(0, 1560)) - 720);
         sel = $urandom_range(0, 9);
         dm  = (sel < 6) ? DST_AUTO : 2'($urandom_range(0, 3));
         set_config(zone, dm);
         gaps = (p % 4 != 3);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            sel        = $urandom_range(0, 99);
            r.mode     = $urandom_range(0, 1);
            if (sel < 70) r.epoch_in = near_switch(zone);
            else if (sel < 90) r.epoch_in = $urandom_range(EPOCH_HI, EPOCH_LO);
            else r.epoch_in = $urandom;
            send_beat(r, 1'b0, w, gaps);
         end
      end
      req_valid <= 1'b0;
      drain();

      $display("Run: %0d beats sent, %0d results checked (%0d in summer time), %0d configs",
               n_sent, n_checked, n_summer, n_configs);
      if (n_errors == 0 && expected_q.size() == 0)
         $display("Testbench completed without errors");
      else begin
         $display("%0d mismatches, %0d results missing", n_errors, expected_q.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
